// ----- src/xtk_pkg.sv -----
// Shared types and constants for the XOR trie k-th largest core.
// No dependencies; imported by xtk_front, xtk_back and the top-level core.
`default_nettype none
package xtk_pkg;
  localparam int unsigned MAX_ITEMS  = 1024;
  localparam int unsigned KEY_BITS   = 32;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned NODE_COUNT = MAX_ITEMS * KEY_BITS + 1;
  localparam int unsigned NODE_W     = $clog2(NODE_COUNT);
  localparam int unsigned CNT_W      = $clog2(MAX_ITEMS + 1);
  localparam int unsigned LVL_W      = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_XOR    = 2'd1,
    OP_QUERY  = 2'd2
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [DATA_W-1:0] operand;
  } cmd_t;

  // trie node: child links and pass-through count
  typedef struct packed {
    logic [NODE_W-1:0] lnk1;
    logic [NODE_W-1:0] lnk0;
    logic [CNT_W-1:0]  cnt;
  } node_t;

  localparam int unsigned NODE_BITS = $bits(node_t);

  typedef enum logic [2:0] {
    B_IDLE,
    B_INS,
    B_INS_RD,
    B_INS_FIN,
    B_Q_LOOK,
    B_Q_CNT,
    B_Q_OTH,
    B_OUT
  } back_state_e;
endpackage
`default_nettype wire

// ----- src/xtk_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none
module xtk_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ----- src/xtk_front.sv -----
// Front end: accepts items, classifies the selector, queues commands.
// Depends on xtk_pkg.
`default_nettype none
module xtk_front (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [1:0]            func_i,
  input  wire logic [31:0]           operand_i,
  output logic                       cmd_valid_o,
  output xtk_pkg::cmd_t              cmd_o,
  input  wire logic                  cmd_pop_i
);
  import xtk_pkg::*;

  cmd_t               buf_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [FIFO_AW:0]   cnt_q, cnt_d;
  logic               keep;
  logic               push;
  logic               pop;
  cmd_t               cmd_in;

  // selector 3 is dropped here: it has no effect
  always_comb begin
    keep           = 1'b1;
    cmd_in.operand = operand_i;
    case (func_i)
      2'd0:    cmd_in.op = OP_INSERT;
      2'd1:    cmd_in.op = OP_XOR;
      2'd2:    cmd_in.op = OP_QUERY;
      default: begin
        cmd_in.op = OP_XOR;
        keep      = 1'b0;
      end
    endcase
  end

  assign in_ready_o  = (cnt_q != (FIFO_AW+1)'(FIFO_DEPTH));
  assign push        = in_valid_i && in_ready_o && keep;
  assign cmd_valid_o = (cnt_q != '0);
  assign pop         = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = buf_q[rd_q];

  always_comb begin
    wr_d  = push ? wr_q + 1'b1 : wr_q;
    rd_d  = pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_q] <= cmd_in;
    end
  end
endmodule
`default_nettype wire

// ----- src/xtk_back.sv -----
// Back end: executes insert, xor and query commands against the trie store.
// Depends on xtk_pkg and xtk_ram.
`default_nettype none
module xtk_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cmd_valid_i,
  input  xtk_pkg::cmd_t      cmd_i,
  output logic               cmd_pop_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output logic [31:0]        value_o,
  output logic               found_o
);
  import xtk_pkg::*;

  back_state_e         st_q, st_d;
  node_t               cur_q, cur_d;
  logic [NODE_W-1:0]   addr_q, addr_d;
  logic [NODE_W-1:0]   root0_q, root0_d, root1_q, root1_d;
  logic [NODE_W-1:0]   free_q, free_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [DATA_W-1:0]   mask_q, mask_d;
  logic [LVL_W-1:0]    lvl_q, lvl_d;
  logic [KEY_BITS-1:0] key_q, key_d;
  logic [KEY_BITS-1:0] acc_q, acc_d;
  logic [CNT_W-1:0]    r_q, r_d;
  logic                fnd_q, fnd_d;
  logic                ov_q, ov_d;
  logic [DATA_W-1:0]   val_q, val_d;
  logic                fo_q, fo_d;

  logic                we;
  logic [NODE_W-1:0]   waddr, raddr;
  node_t               wdata, rnode;
  logic [NODE_BITS-1:0] rdata;

  logic                bit_k, pref;
  logic [NODE_W-1:0]   child, pc, oth;
  logic [DATA_W-1:0]   k_eff;
  node_t               upd;

  xtk_ram #(.WIDTH(NODE_BITS), .DEPTH(NODE_COUNT)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign rnode       = node_t'(rdata);
  assign out_valid_o = ov_q;
  assign value_o     = val_q;
  assign found_o     = fo_q;

  always_comb begin
    st_d    = st_q;
    cur_d   = cur_q;
    addr_d  = addr_q;
    root0_d = root0_q;
    root1_d = root1_q;
    free_d  = free_q;
    count_d = count_q;
    mask_d  = mask_q;
    lvl_d   = lvl_q;
    key_d   = key_q;
    acc_d   = acc_q;
    r_d     = r_q;
    fnd_d   = fnd_q;
    ov_d    = ov_q && !out_ready_i;
    val_d   = val_q;
    fo_d    = fo_q;
    cmd_pop_o = 1'b0;
    we      = 1'b0;
    waddr   = addr_q;
    wdata   = cur_q;
    raddr   = addr_q;
    upd     = cur_q;

    bit_k = key_q[lvl_q];
    child = bit_k ? cur_q.lnk1 : cur_q.lnk0;
    pref  = ~mask_q[lvl_q];
    pc    = pref ? cur_q.lnk1 : cur_q.lnk0;
    oth   = pref ? cur_q.lnk0 : cur_q.lnk1;
    k_eff = (cmd_i.operand == '0) ? DATA_W'(1) : cmd_i.operand;

    case (st_q)
      B_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          key_d     = cmd_i.operand[KEY_BITS-1:0];
          lvl_d     = LVL_W'(KEY_BITS - 1);
          cur_d     = '{lnk1: root1_q, lnk0: root0_q, cnt: '0};
          addr_d    = '0;
          acc_d     = '0;
          case (cmd_i.op)
            OP_INSERT: begin
              if (count_q < CNT_W'(MAX_ITEMS)) begin
                count_d = count_q + 1'b1;
                st_d    = B_INS;
              end
            end
            OP_XOR: mask_d = mask_q ^ cmd_i.operand;
            OP_QUERY: begin
              if (k_eff > DATA_W'(count_q)) begin
                fnd_d = 1'b0;
                st_d  = B_OUT;
              end else begin
                r_d  = k_eff[CNT_W-1:0];
                st_d = B_Q_LOOK;
              end
            end
            default: st_d = B_IDLE;
          endcase
        end
      end
      B_INS: begin
        if (child == '0) begin
          upd = cur_q;
          if (bit_k) upd.lnk1 = free_q;
          else       upd.lnk0 = free_q;
          addr_d = free_q;
          free_d = free_q + 1'b1;
          cur_d  = '{lnk1: '0, lnk0: '0, cnt: CNT_W'(1)};
          if (lvl_q == '0) st_d = B_INS_FIN;
          else             lvl_d = lvl_q - 1'b1;
        end else begin
          addr_d = child;
          raddr  = child;
          st_d   = B_INS_RD;
        end
        // write the current node back; the root lives in flops
        wdata = upd;
        if (addr_q == '0) begin
          root0_d = upd.lnk0;
          root1_d = upd.lnk1;
        end else begin
          we = 1'b1;
        end
      end
      B_INS_RD: begin
        cur_d     = rnode;
        cur_d.cnt = rnode.cnt + 1'b1;
        if (lvl_q == '0) begin
          st_d = B_INS_FIN;
        end else begin
          lvl_d = lvl_q - 1'b1;
          st_d  = B_INS;
        end
      end
      B_INS_FIN: begin
        we   = 1'b1;
        st_d = B_IDLE;
      end
      B_Q_LOOK: begin
        if (pc != '0) begin
          raddr = pc;
          st_d  = B_Q_CNT;
        end else begin
          raddr = oth;
          acc_d = {acc_q[KEY_BITS-2:0], ~pref};
          st_d  = B_Q_OTH;
        end
      end
      B_Q_CNT: begin
        if (r_q <= rnode.cnt) begin
          cur_d = rnode;
          acc_d = {acc_q[KEY_BITS-2:0], pref};
          if (lvl_q == '0) begin
            fnd_d = 1'b1;
            st_d  = B_OUT;
          end else begin
            lvl_d = lvl_q - 1'b1;
            st_d  = B_Q_LOOK;
          end
        end else begin
          r_d   = r_q - rnode.cnt;
          raddr = oth;
          acc_d = {acc_q[KEY_BITS-2:0], ~pref};
          st_d  = B_Q_OTH;
        end
      end
      B_Q_OTH: begin
        cur_d = rnode;
        if (lvl_q == '0) begin
          fnd_d = 1'b1;
          st_d  = B_OUT;
        end else begin
          lvl_d = lvl_q - 1'b1;
          st_d  = B_Q_LOOK;
        end
      end
      B_OUT: begin
        if (!ov_q || out_ready_i) begin
          ov_d = 1'b1;
          fo_d = fnd_q;
          val_d = fnd_q ? (DATA_W'(acc_q) ^ mask_q) : '0;
          st_d = B_IDLE;
        end
      end
      default: st_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= B_IDLE;
      root0_q <= '0;
      root1_q <= '0;
      free_q  <= NODE_W'(1);
      count_q <= '0;
      mask_q  <= '0;
      ov_q    <= 1'b0;
    end else begin
      st_q    <= st_d;
      root0_q <= root0_d;
      root1_q <= root1_d;
      free_q  <= free_d;
      count_q <= count_d;
      mask_q  <= mask_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    addr_q <= addr_d;
    lvl_q  <= lvl_d;
    key_q  <= key_d;
    acc_q  <= acc_d;
    r_q    <= r_d;
    fnd_q  <= fnd_d;
    val_q  <= val_d;
    fo_q   <= fo_d;
  end
endmodule
`default_nettype wire

// ----- src/xor_trie_kth_largest_core.sv -----
// XOR trie k-th largest core. In the back end an xor only updates the mask;
// an insert walks the trie one level at a time, either allocating a new node
// or reading an existing node from node memory at each level; a query reads
// node memory at each level, and answers without a walk when the rank is
// beyond the stored count. The single node memory has a registered read.
// Reset (async, active low) clears the queue, root links, count and mask.
`default_nettype none
module xor_trie_kth_largest_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  func_i,
  input  wire logic [31:0] operand_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      value_o,
  output logic             found_o
);
  import xtk_pkg::*;

  cmd_t cmd;
  logic cmd_valid;
  logic cmd_pop;

  // front: accepts and queues items, four deep
  xtk_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .func_i      (func_i),
    .operand_i   (operand_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  // back: walks the trie one level at a time, output register at the end
  xtk_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .value_o     (value_o),
    .found_o     (found_o)
  );
endmodule
`default_nettype wire
